/* rtl/slq_pkg.sv */
package slq_pkg;

    // Channel counts and time width, fixed by the item layout
    localparam int NumSwitches = 6;
    localparam int NumMotion   = 3;
    localparam int TimeBits    = 32;
    localparam int PinBits     = NumSwitches + NumMotion;

    // Configuration register widths and reset values
    localparam int LockoutBits = 8;
    localparam int HoldBits    = 16;
    localparam int CfgIdxBits  = 2;
    localparam int CfgDataBits = 16;

    localparam logic [LockoutBits-1:0] LockoutReset = LockoutBits'(2);
    localparam logic [HoldBits-1:0]    HoldReset    = HoldBits'(30);
    localparam logic [NumMotion-1:0]   InvertReset  = NumMotion'(1);

    // Configuration register indexes
    localparam logic [CfgIdxBits-1:0] CfgLockout = 2'd0;
    localparam logic [CfgIdxBits-1:0] CfgHold    = 2'd1;
    localparam logic [CfgIdxBits-1:0] CfgInvert  = 2'd2;

    // Item commands
    localparam logic CmdUpdate = 1'b0;
    localparam logic CmdLoad   = 1'b1;

    typedef struct packed {
        logic                command;
        logic [PinBits-1:0]  pin_mask;
        logic [TimeBits-1:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [NumSwitches-1:0] switch_changed;
        logic [NumMotion-1:0]   motion_triggered;
        logic [NumSwitches-1:0] switch_levels;
        logic                   every_closed;
        logic                   no_motion;
    } t_out_item;

    // What one switch lane reports to the merge stage
    typedef struct packed {
        logic changed;
        logic level;
    } t_sw_res;

    // What one motion lane reports to the merge stage
    typedef struct packed {
        logic triggered;
        logic active;
    } t_mo_res;

endpackage

/* rtl/sensor_lockout_qualifier.sv */
// The result of an accepted item is in the output register in the next cycle.
// Throughput: one item per cycle while no held result stalls the input; each lane
// does one 32-bit subtract and compare on its start time; all lanes share each item.
// Reset (synchronous, active low): latched levels, lockouts and holds clear,
// configuration returns to lockout 2 s, hold 30 s, invert mask 1; output empty.
module sensor_lockout_qualifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [slq_pkg::CfgIdxBits-1:0]     i_cfg_idx,
    input  logic [slq_pkg::CfgDataBits-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  slq_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output slq_pkg::t_out_item                 o_out_data
);

    logic [slq_pkg::LockoutBits-1:0] r_lockout_len;
    logic [slq_pkg::HoldBits-1:0]    r_hold_len;
    logic [slq_pkg::NumMotion-1:0]   r_invert;

    logic             w_accept;
    slq_pkg::t_sw_res w_sw_res [slq_pkg::NumSwitches];
    slq_pkg::t_mo_res w_mo_res [slq_pkg::NumMotion];

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_len <= slq_pkg::LockoutReset;
            r_hold_len    <= slq_pkg::HoldReset;
            r_invert      <= slq_pkg::InvertReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slq_pkg::CfgLockout: begin
                    r_lockout_len <= i_cfg_wdata[slq_pkg::LockoutBits-1:0];
                end
                slq_pkg::CfgHold: begin
                    r_hold_len <= i_cfg_wdata[slq_pkg::HoldBits-1:0];
                end
                slq_pkg::CfgInvert: begin
                    r_invert <= i_cfg_wdata[slq_pkg::NumMotion-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;

    // One lane per contact switch
    for (genvar gs = 0; gs < slq_pkg::NumSwitches; gs++) begin : g_sw
        slq_switch_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (w_accept),
            .i_command (i_in_data.command),
            .i_pin     (i_in_data.pin_mask[gs]),
            .i_now     (i_in_data.now_seconds),
            .i_len     (r_lockout_len),
            .o_res     (w_sw_res[gs])
        );
    end

    // One lane per motion sensor
    for (genvar gm = 0; gm < slq_pkg::NumMotion; gm++) begin : g_mo
        slq_motion_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (w_accept),
            .i_command (i_in_data.command),
            .i_pin     (i_in_data.pin_mask[slq_pkg::NumSwitches + gm]),
            .i_invert  (r_invert[gm]),
            .i_now     (i_in_data.now_seconds),
            .i_len     (r_hold_len),
            .o_res     (w_mo_res[gm])
        );
    end

    // Combine lane findings and register the result item
    slq_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_sw_res    (w_sw_res),
        .i_mo_res    (w_mo_res),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted item left no result");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.command == slq_pkg::CmdLoad) |=>
        (o_out_data.switch_changed == '0 && o_out_data.motion_triggered == '0))
        else $error("load command reported events");

    a_trigger_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (|o_out_data.motion_triggered)) |-> !o_out_data.no_motion)
        else $error("trigger without an active hold");
`endif

endmodule

/* rtl/slq_switch_lane.sv */
module slq_switch_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_command,
    input  logic                                i_pin,
    input  logic [slq_pkg::TimeBits-1:0]        i_now,
    input  logic [slq_pkg::LockoutBits-1:0]     i_len,
    output slq_pkg::t_sw_res                    o_res
);

    logic                         r_level;
    logic                         r_active;
    logic [slq_pkg::TimeBits-1:0] r_start;
    logic                         n_level;
    logic                         n_active;
    logic [slq_pkg::TimeBits-1:0] n_start;

    logic [slq_pkg::TimeBits-1:0] w_elapsed;
    logic                         w_expired;
    logic                         w_running;
    logic                         w_change;

    // Elapsed time wraps; a lockout runs until elapsed strictly exceeds it
    assign w_elapsed = i_now - r_start;
    assign w_expired = w_elapsed >
                       {{(slq_pkg::TimeBits - slq_pkg::LockoutBits){1'b0}}, i_len};
    assign w_running = r_active && !w_expired;
    assign w_change  = (i_command == slq_pkg::CmdUpdate) && !w_running && (r_level != i_pin);

    // Latch a new level, start or drop the lockout
    always_comb begin
        n_level  = r_level;
        n_active = r_active;
        n_start  = r_start;
        if (i_command == slq_pkg::CmdLoad) begin
            n_level  = i_pin;
            n_active = 1'b0;
        end else if (w_change) begin
            n_level  = i_pin;
            n_active = 1'b1;
            n_start  = i_now;
        end else if (r_active && w_expired) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= 1'b0;
            r_active <= 1'b0;
        end else if (i_accept) begin
            r_level  <= n_level;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start <= n_start;
        end
    end

    assign o_res.changed = w_change;
    assign o_res.level   = n_level;

endmodule

/* rtl/slq_motion_lane.sv */
module slq_motion_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic                             i_command,
    input  logic                             i_pin,
    input  logic                             i_invert,
    input  logic [slq_pkg::TimeBits-1:0]     i_now,
    input  logic [slq_pkg::HoldBits-1:0]     i_len,
    output slq_pkg::t_mo_res                 o_res
);

    logic                         r_active;
    logic [slq_pkg::TimeBits-1:0] r_start;
    logic                         n_active;
    logic [slq_pkg::TimeBits-1:0] n_start;

    logic [slq_pkg::TimeBits-1:0] w_elapsed;
    logic                         w_expired;
    logic                         w_busy;
    logic                         w_trigger;

    // A hold runs until the wrapped elapsed time strictly exceeds it
    assign w_elapsed = i_now - r_start;
    assign w_expired = w_elapsed >
                       {{(slq_pkg::TimeBits - slq_pkg::HoldBits){1'b0}}, i_len};
    assign w_busy    = r_active && !w_expired;
    assign w_trigger = (i_command == slq_pkg::CmdUpdate) && (i_pin ^ i_invert) && !w_busy;

    // Start a hold on a trigger, drop an expired one; loads leave holds alone
    always_comb begin
        n_active = r_active;
        n_start  = r_start;
        if (w_trigger) begin
            n_active = 1'b1;
            n_start  = i_now;
        end else if ((i_command == slq_pkg::CmdUpdate) && r_active && w_expired) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_accept) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start <= n_start;
        end
    end

    assign o_res.triggered = w_trigger;
    assign o_res.active    = n_active;

endmodule

/* rtl/slq_merge.sv */
module slq_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  slq_pkg::t_sw_res   i_sw_res [slq_pkg::NumSwitches],
    input  slq_pkg::t_mo_res   i_mo_res [slq_pkg::NumMotion],
    input  logic               i_out_stall,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output slq_pkg::t_out_item o_out_data
);

    logic               r_valid;
    logic               n_valid;
    slq_pkg::t_out_item r_data;
    slq_pkg::t_out_item n_data;

    logic [slq_pkg::NumSwitches-1:0] w_changed;
    logic [slq_pkg::NumSwitches-1:0] w_levels;
    logic [slq_pkg::NumMotion-1:0]   w_trig;
    logic [slq_pkg::NumMotion-1:0]   w_active;

    // Gather lane findings into vectors
    always_comb begin
        for (int i = 0; i < slq_pkg::NumSwitches; i++) begin
            w_changed[i] = i_sw_res[i].changed;
            w_levels[i]  = i_sw_res[i].level;
        end
        for (int j = 0; j < slq_pkg::NumMotion; j++) begin
            w_trig[j]   = i_mo_res[j].triggered;
            w_active[j] = i_mo_res[j].active;
        end
    end

    // Build the result item
    always_comb begin
        n_data.switch_changed   = w_changed;
        n_data.motion_triggered = w_trig;
        n_data.switch_levels    = w_levels;
        n_data.every_closed     = &w_levels;
        n_data.no_motion        = ~|w_active;
    end

    // Hold the result until taken; a new item may replace one being taken
    assign o_in_stall = r_valid && i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_data <= n_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* tb/sv/slq_result_checker.sv */
`timescale 1ns / 100ps

module slq_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [slq_pkg::CfgIdxBits-1:0]  i_cfg_idx,
    input  logic [slq_pkg::CfgDataBits-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  slq_pkg::t_in_item               i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  slq_pkg::t_out_item              i_out_data,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    import slq_pkg::*;

    // Register copies
    logic [LockoutBits-1:0] lockout_len;
    logic [HoldBits-1:0]    hold_len;
    logic [NumMotion-1:0]   invert_mask;

    // Per-switch debounce state and per-sensor hold state
    logic [NumSwitches-1:0] sw_level;
    logic [NumSwitches-1:0] sw_locked;
    logic [TimeBits-1:0]    sw_since [NumSwitches];
    logic [NumMotion-1:0]   mo_busy;
    logic [TimeBits-1:0]    mo_since [NumMotion];

    t_out_item expected_results [$];
    int        fail_total;
    int        results_checked;

    initial begin
        fail_total      = 0;
        results_checked = 0;
        o_fail_count    = 0;
        o_pending       = 0;
        o_checked       = 0;
    end

    // Advance the debounce and hold state by one item and return its result
    function automatic t_out_item qualify_item(t_in_item item);
        t_out_item           res;
        logic [TimeBits-1:0] elapsed;
        logic                pin;
        res = '0;
        for (int i = 0; i < NumSwitches; i++) begin
            pin = item.pin_mask[i];
            if (item.command == CmdLoad) begin
                sw_level[i]  = pin;
                sw_since[i]  = '0;
                sw_locked[i] = 1'b0;
            end else begin
                // expire the lockout only once elapsed strictly exceeds it
                elapsed = item.now_seconds - sw_since[i];
                if (sw_locked[i] && elapsed > lockout_len)
                    sw_locked[i] = 1'b0;
                if (!sw_locked[i] && sw_level[i] != pin) begin
                    sw_level[i]            = pin;
                    sw_since[i]            = item.now_seconds;
                    sw_locked[i]           = 1'b1;
                    res.switch_changed[i]  = 1'b1;
                end
            end
        end
        res.switch_levels = sw_level;
        res.every_closed  = &sw_level;

        // Loads leave the holds untouched
        if (item.command == CmdUpdate) begin
            for (int i = 0; i < NumMotion; i++) begin
                pin     = item.pin_mask[NumSwitches + i] ^ invert_mask[i];
                elapsed = item.now_seconds - mo_since[i];
                if (mo_busy[i] && elapsed > hold_len)
                    mo_busy[i] = 1'b0;
                if (pin && !mo_busy[i]) begin
                    mo_busy[i]               = 1'b1;
                    mo_since[i]              = item.now_seconds;
                    res.motion_triggered[i]  = 1'b1;
                end
            end
        end
        res.no_motion = ~|mo_busy;
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            lockout_len = LockoutReset;
            hold_len    = HoldReset;
            invert_mask = InvertReset;
            sw_level    = '0;
            sw_locked   = '0;
            mo_busy     = '0;
            for (int i = 0; i < NumSwitches; i++) sw_since[i] = '0;
            for (int i = 0; i < NumMotion; i++) mo_since[i] = '0;
            expected_results.delete();
        end else begin
            // Compare the outgoing item against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result %0h arrived with nothing pending", i_out_data);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("switch_changed", 8'(want.switch_changed),
                                8'(i_out_data.switch_changed));
                    check_field("motion_triggered", 8'(want.motion_triggered),
                                8'(i_out_data.motion_triggered));
                    check_field("switch_levels", 8'(want.switch_levels),
                                8'(i_out_data.switch_levels));
                    check_field("every_closed", 8'(want.every_closed),
                                8'(i_out_data.every_closed));
                    check_field("no_motion", 8'(want.no_motion), 8'(i_out_data.no_motion));
                    results_checked++;
                end
            end

            // Track register writes, dropping unknown indexes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgLockout: lockout_len = i_cfg_wdata[LockoutBits-1:0];
                    CfgHold:    hold_len    = i_cfg_wdata[HoldBits-1:0];
                    CfgInvert:  invert_mask = i_cfg_wdata[NumMotion-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall)
                expected_results.push_back(qualify_item(i_in_data));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
        o_checked    <= results_checked;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import slq_pkg::*;

    localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;
    localparam int WatchdogLimit = 2000;
    localparam int HoldOffCycles = 64;
    localparam int SettleCycles  = 4;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CfgIdxBits-1:0]  i_cfg_idx;
    logic [CfgDataBits-1:0] i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_item               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_item              o_out_data;

    int fail_count;
    int pending;
    int checked;

    int idle_cycles;
    bit quiet;
    bit hold_off_req;
    int hold_off_left;

    logic [PinBits-1:0]  cur_pins;
    logic [TimeBits-1:0] cur_time;
    int items_sent;
    int loads_sent;
    int settings_used;

    sensor_lockout_qualifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    slq_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off on request
    initial begin
        hold_off_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req  = 1'b0;
                hold_off_left = HoldOffCycles;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(0, 99) < 10);
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     idle_cycles, pending);
            $display("sensor_lockout_qualifier regression: fail");
            $finish;
        end
    end

    // Offer one item at a falling edge and hold it until accepted
    task automatic send_item(input logic cmd, input logic [PinBits-1:0] pins,
                             input logic [TimeBits-1:0] t);
        while (!quiet && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{command: cmd, pin_mask: pins, now_seconds: t};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        cur_pins = pins;
        cur_time = t;
        items_sent++;
        if (cmd == CmdLoad)
            loads_sent++;
    endtask

    // Mostly small pin changes and short time steps, with jumps and noise
    task automatic send_random(input int count);
        logic [PinBits-1:0]  pins;
        logic [TimeBits-1:0] t;
        logic                cmd;
        int                  pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pins = cur_pins ^ (PinBits'(1) << $urandom_range(0, PinBits - 1));
            else if (pick < 85)
                pins = cur_pins;
            else
                pins = PinBits'($urandom);

            pick = $urandom_range(0, 99);
            if (pick < 40)
                t = cur_time;
            else if (pick < 75)
                t = cur_time + 1;
            else if (pick < 85)
                t = cur_time + TimeBits'($urandom_range(2, 8));
            else if (pick < 92)
                t = cur_time + TimeBits'($urandom_range(0, 300));
            else if (pick < 96)
                t = cur_time + TimeBits'($urandom_range(0, 70000));
            else
                t = TimeBits'($urandom);

            cmd = ($urandom_range(0, 24) == 0) ? CmdLoad : CmdUpdate;
            send_item(cmd, pins, t);
        end
    endtask

    // Drop valid and wait until every prediction has been matched
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                             input logic [CfgDataBits-1:0] data);
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Unused upper data bits carry noise to exercise masking
    task automatic apply_settings(input logic [LockoutBits-1:0] lock,
                                  input logic [HoldBits-1:0] hold,
                                  input logic [NumMotion-1:0] inv);
        drain();
        write_reg(CfgLockout, {8'($urandom), lock});
        write_reg(CfgHold, hold);
        write_reg(CfgInvert, {13'($urandom), inv});
        settings_used++;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        quiet         = 1'b0;
        hold_off_req  = 1'b0;
        cur_pins      = '0;
        cur_time      = '0;
        items_sent    = 0;
        loads_sent    = 0;
        settings_used = 1;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: lockout edges, load, hold expiry, time wrap
        send_item(CmdUpdate, 9'h000, 32'd0);
        send_item(CmdUpdate, 9'h1FF, 32'd0);
        send_item(CmdUpdate, 9'h1C0, 32'd1);
        send_item(CmdUpdate, 9'h1C0, 32'd2);
        send_item(CmdUpdate, 9'h1C0, 32'd3);
        send_item(CmdLoad,   9'h155, 32'd3);
        send_item(CmdUpdate, 9'h02A, 32'd3);
        send_item(CmdUpdate, 9'h000, 32'd31);
        send_item(CmdUpdate, 9'h040, 32'd62);
        send_item(CmdUpdate, 9'h03F, 32'hFFFF_FFFE);
        send_item(CmdUpdate, 9'h000, 32'hFFFF_FFFF);
        send_item(CmdUpdate, 9'h000, 32'd0);
        send_item(CmdUpdate, 9'h000, 32'd1);

        // Zero-length lockout and hold, all sensors active low, unknown index
        apply_settings(8'd0, 16'd0, 3'h7);
        write_reg(CfgUnused, 16'($urandom));
        send_item(CmdUpdate, 9'h03F, 32'd100);
        send_item(CmdUpdate, 9'h000, 32'd100);
        send_item(CmdUpdate, 9'h000, 32'd101);
        send_item(CmdUpdate, 9'h1C0, 32'd101);
        send_item(CmdLoad,   9'h1FF, 32'd200);
        send_random(90);

        // Longest lockout and hold, no inversion, running across the wrap
        apply_settings(8'd255, 16'hFFFF, 3'h0);
        cur_time = 32'hFFFF_FF00;
        send_random(90);

        // Short random lengths; stall the output long enough to back up the input
        apply_settings(8'($urandom_range(1, 6)), 16'($urandom_range(1, 12)),
                       3'($urandom));
        hold_off_req = 1'b1;
        send_random(120);

        // Reset values again with no idling on either side
        apply_settings(8'd2, 16'd30, 3'h1);
        quiet = 1'b1;
        send_random(110);
        quiet = 1'b0;

        // Random lockout and invert mask, random hold of at most 50
        apply_settings(8'($urandom), 16'($urandom_range(0, 50)), 3'($urandom));
        send_random(120);

        drain();
        $display("covered %0d items (%0d loads) under %0d register settings", items_sent,
                 loads_sent, settings_used);
        $display("compared %0d results, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("sensor_lockout_qualifier regression: pass");
        else
            $display("sensor_lockout_qualifier regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/slq_pkg.sv
rtl/slq_switch_lane.sv
rtl/slq_motion_lane.sv
rtl/slq_merge.sv
rtl/sensor_lockout_qualifier.sv
tb/sv/slq_result_checker.sv
tb/sv/tb_top.sv
